@@ rtl/core/itra_pkg.sv @@
// itra_pkg: shared constants, command/status structs and the digit-to-ascii function
// for the integer-to-radix ascii unit; no dependencies
package itra_pkg;

  localparam int ITRA_VALUE_WIDTH = 32;
  localparam int RADIX_W          = 6;
  localparam int CHAR_W           = 7;
  localparam int BITS_PER_CYCLE   = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] DIGIT_NINE  = 6'd9;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A     = 7'h61;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0] ASCII_Z     = 7'h7a;
  localparam logic [CHAR_W-1:0] TEN_OFFSET  = 7'd10;

  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic emit_sign;
    logic rd;
    logic emit_digit;
  } itra_cmd_t;

  typedef struct packed {
    logic quot_zero;
    logic neg;
    logic idx_one;
  } itra_status_t;

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d > DIGIT_NINE) begin
      return dx - TEN_OFFSET + ASCII_A;
    end
    return dx + ASCII_ZERO;
  endfunction

endpackage

@@ rtl/core/itra_ram.sv @@
// itra_ram: generic single-write, single-read ram with registered read data
// no dependencies
module itra_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/itra_ctrl.sv @@
// itra_ctrl: controller state machine sequencing divide, store and emit phases
// depends on itra_pkg
module itra_ctrl import itra_pkg::*; #(
  parameter int VALUE_WIDTH = ITRA_VALUE_WIDTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  itra_status_t status,
  output itra_cmd_t    cmd
);

  localparam int DIV_W = ((VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE) * BITS_PER_CYCLE;
  localparam int STEPS = DIV_W / BITS_PER_CYCLE;
  localparam int SC_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [SC_W-1:0] STEP_LAST = SC_W'(STEPS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_STORE = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]      st_r, st_nxt;
  logic [SC_W-1:0] step_r, step_nxt;

  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    cmd      = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          step_nxt = '0;
          st_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          st_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        step_nxt  = '0;
        st_nxt    = status.quot_zero ? ST_SIGN : ST_DIV;
      end
      ST_SIGN: begin
        cmd.emit_sign = status.neg;
        st_nxt        = ST_RD;
      end
      ST_RD: begin
        cmd.rd = 1'b1;
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        cmd.emit_digit = 1'b1;
        st_nxt         = status.idx_one ? ST_IDLE : ST_RD;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      step_r <= '0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
    end
  end

  assign busy = (st_r != ST_IDLE);

endmodule

@@ rtl/core/itra_dpath.sv @@
// itra_dpath: radix register, shift-subtract divider, digit count, output registers
// depends on itra_pkg and itra_ram
module itra_dpath import itra_pkg::*; #(
  parameter int VALUE_WIDTH = ITRA_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  itra_cmd_t              cmd,
  output itra_status_t           status,
  input  logic                   cfg_we,
  input  logic [RADIX_W-1:0]     cfg_radix,
  input  logic [VALUE_WIDTH-1:0] value_in,
  output logic                   out_valid,
  output logic [CHAR_W-1:0]      out_digit_char,
  output logic                   out_last_char
);

  localparam int DIV_W = ((VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE) * BITS_PER_CYCLE;
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int AW    = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

  logic [RADIX_W-1:0] radix_r;
  logic [RADIX_W-1:0] base;
  logic [DIV_W-1:0]   sh_r, sh_nxt;
  logic [RADIX_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;
  logic               valid_r, valid_nxt;
  logic [CHAR_W-1:0]  char_r, char_nxt;
  logic               last_r, last_nxt;
  logic [VALUE_WIDTH-1:0] v_raw;
  logic [VALUE_WIDTH-1:0] v_neg;
  logic               is_neg;
  logic [DIV_W-1:0]   step_sh;
  logic [RADIX_W-1:0] step_rem;
  logic [RADIX_W:0]   trial;
  logic [CNT_W-1:0]   rd_idx;
  logic [RADIX_W-1:0] rd_digit;

  always_comb begin
    if (radix_r < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix_r;
    end
  end

  assign v_raw  = value_in;
  assign v_neg  = '0 - v_raw;
  assign is_neg = (base == RADIX_DEC) && v_raw[VALUE_WIDTH-1];

  // eight restoring division steps per cycle, applied while cmd.div_step is set
  always_comb begin
    step_sh  = sh_r;
    step_rem = rem_r;
    trial    = '0;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      trial   = {step_rem, step_sh[DIV_W-1]};
      step_sh = {step_sh[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, base}) begin
        trial      = trial - {1'b0, base};
        step_sh[0] = 1'b1;
      end
      step_rem = trial[RADIX_W-1:0];
    end
  end

  assign rd_idx = cnt_r - 1'b1;

  itra_ram #(
    .WIDTH (RADIX_W),
    .DEPTH (VALUE_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (cnt_r[AW-1:0]),
    .wdata (rem_r),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_digit)
  );

  always_comb begin
    sh_nxt    = sh_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    valid_nxt = 1'b0;
    char_nxt  = char_r;
    last_nxt  = last_r;
    if (cmd.load) begin
      sh_nxt  = DIV_W'(is_neg ? v_neg : v_raw);
      rem_nxt = '0;
      cnt_nxt = '0;
      neg_nxt = is_neg;
    end
    if (cmd.div_step) begin
      sh_nxt  = step_sh;
      rem_nxt = step_rem;
    end
    if (cmd.store) begin
      cnt_nxt = cnt_r + 1'b1;
      rem_nxt = '0;
    end
    if (cmd.emit_sign) begin
      valid_nxt = 1'b1;
      char_nxt  = ASCII_MINUS;
      last_nxt  = 1'b0;
    end
    if (cmd.emit_digit) begin
      valid_nxt = 1'b1;
      char_nxt  = digit_ascii(rd_digit);
      last_nxt  = (cnt_r == CNT_W'(1));
      cnt_nxt   = rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
      cnt_r   <= '0;
      neg_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        radix_r <= cfg_radix;
      end
      cnt_r   <= cnt_nxt;
      neg_r   <= neg_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    rem_r  <= rem_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign status.quot_zero = (sh_r == '0);
  assign status.neg       = neg_r;
  assign status.idx_one   = (cnt_r == CNT_W'(1));

  assign out_valid      = valid_r;
  assign out_digit_char = char_r;
  assign out_last_char  = last_r;

endmodule

@@ rtl/core/integer_to_radix_ascii_unit.sv @@
// integer_to_radix_ascii_unit: top level, converts one integer per transaction into
// ascii digits in the configured radix; depends on itra_pkg, itra_ctrl, itra_dpath
// sequence: a load, then for each digit a run of divider steps and a store, then
//   a sign slot, then the digits read back from the store, most significant first
// a new value is accepted only while busy is low
// reset: synchronous active-low, radix returns to 10, unit idle; results cannot stall
module integer_to_radix_ascii_unit import itra_pkg::*; #(
  parameter int VALUE_WIDTH = ITRA_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  output logic [CHAR_W-1:0]             out_digit_char,
  output logic                          out_last_char,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [RADIX_W-1:0]            cfg_radix
);

  itra_cmd_t    cmd;
  itra_status_t status;
  logic         busy_w;

  itra_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy_w),
    .status (status),
    .cmd    (cmd)
  );

  itra_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_radix      (cfg_radix),
    .value_in       (in_value),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last_char  (out_last_char)
  );

  assign busy      = busy_w;
  assign cfg_ready = !busy_w && !start;

endmodule

@@ rtl/core/itra_checker.sv @@
// itra_checker: port-level assertions for integer_to_radix_ascii_unit, bound to the top
// depends on itra_pkg
module itra_checker import itra_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [CHAR_W-1:0] out_digit_char,
  input logic              out_last_char
);

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_out_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_char |-> busy)
    else $error("character strobed while idle");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_char |-> !busy ##1 !out_valid)
    else $error("unit still active after last character");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char == ASCII_MINUS)
      || (out_digit_char >= ASCII_ZERO && out_digit_char <= ASCII_NINE)
      || (out_digit_char >= ASCII_A && out_digit_char <= ASCII_Z))
    else $error("illegal output character");

endmodule

bind integer_to_radix_ascii_unit itra_checker u_itra_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_digit_char (out_digit_char),
  .out_last_char  (out_last_char)
);
